### hw/rtl/cscd_pkg.sv
// Package for the CAN status frame decoder: frame identifiers, signal codes,
// queue sizing and the frame descriptor passed from front to back end.
// Depends on nothing; used by every module of the decoder.
`timescale 1ns / 1ps

package cscd_pkg;

  // Frame identifiers, compared as whole 29-bit values.
  localparam logic [28:0] ID_EPS     = 29'h1802A0B0;
  localparam logic [28:0] ID_DRIVE   = 29'h1804A0B0;
  localparam logic [28:0] ID_VEHICLE = 29'h1806A0B0;
  localparam logic [28:0] ID_BATTERY = 29'h1810A0B0;
  localparam logic [28:0] ID_POWER   = 29'h1812A0B0;
  localparam logic [28:0] ID_FAULT   = 29'h1813A0B0;
  localparam logic [28:0] ID_BRAKE   = 29'h602;

  // Signal codes, numbered densely in frame and field order.
  localparam logic [4:0] SC_EPS_RUN_MODE   = 5'd0;
  localparam logic [4:0] SC_EPS_DRV_TORQUE = 5'd1;
  localparam logic [4:0] SC_EPS_TORQUE     = 5'd2;
  localparam logic [4:0] SC_EPS_ANGLE      = 5'd3;
  localparam logic [4:0] SC_EPS_TEMP       = 5'd4;
  localparam logic [4:0] SC_EPS_ERR_LEVEL  = 5'd5;
  localparam logic [4:0] SC_EPS_LINK       = 5'd6;
  localparam logic [4:0] SC_DRV_EPB        = 5'd7;
  localparam logic [4:0] SC_DRV_GEAR       = 5'd8;
  localparam logic [4:0] SC_DRV_MOT_SPEED  = 5'd9;
  localparam logic [4:0] SC_DRV_MOT_TORQUE = 5'd10;
  localparam logic [4:0] SC_DRV_ACCEL      = 5'd11;
  localparam logic [4:0] SC_DRV_LINK       = 5'd12;
  localparam logic [4:0] SC_VEH_DRV_MODE   = 5'd13;
  localparam logic [4:0] SC_VEH_DOOR       = 5'd14;
  localparam logic [4:0] SC_VEH_SPEED      = 5'd15;
  localparam logic [4:0] SC_VEH_SOC        = 5'd16;
  localparam logic [4:0] SC_VEH_SMART_PWR  = 5'd17;
  localparam logic [4:0] SC_VEH_CHG_STATE  = 5'd18;
  localparam logic [4:0] SC_VEH_CHG_CONN   = 5'd19;
  localparam logic [4:0] SC_VEH_FAULT_LVL  = 5'd20;
  localparam logic [4:0] SC_VEH_LINK       = 5'd21;
  localparam logic [4:0] SC_BAT_VOLTAGE    = 5'd22;
  localparam logic [4:0] SC_BAT_CURRENT    = 5'd23;
  localparam logic [4:0] SC_PWR_STATE      = 5'd24;
  localparam logic [4:0] SC_FLT_ISOLATION  = 5'd25;
  localparam logic [4:0] SC_FLT_BMS        = 5'd26;
  localparam logic [4:0] SC_FLT_MCU        = 5'd27;
  localparam logic [4:0] SC_BRK_MODE       = 5'd28;
  localparam logic [4:0] SC_BRK_FORCE      = 5'd29;
  localparam logic [4:0] SC_BRK_LINK       = 5'd30;

  // Reciprocal of five: floor(x * 52429 / 2^18) equals floor(x / 5) for 16-bit x.
  localparam logic [15:0] RECIP5       = 16'd52429;
  localparam int unsigned RECIP5_SHIFT = 18;
  localparam int unsigned QUOT_W       = 14;

  // Descriptor queue between front and back end.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  localparam logic [7:0] HB_RESET = 8'hFF;

  // One classified frame: the range of codes to emit plus the data they need.
  typedef struct packed {
    logic [4:0]        first_code;
    logic [4:0]        last_code;
    logic [6:0][7:0]   data;
    logic              link_ok;
    logic [QUOT_W-1:0] quot;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### hw/rtl/can_status_frame_decoder_unit.sv
// Top level of the CAN status frame decoder.
// Instantiates cscd_front, cscd_queue and cscd_back; depends on cscd_pkg.
`timescale 1ns / 1ps

// The decoder takes one received CAN frame per transfer (identifier plus
// eight data bytes) and returns a run of decoded signals, each as a signal
// code, a signed 17-bit value and a flag marking the final result of the
// frame. Seven identifiers are recognised; every other identifier is taken
// and discarded without any result or change of state. Both sides behave as
// queues: a frame is taken when push is high and full is low, and the
// oldest result is taken when pop is high and empty is low. The front
// end classifies a frame in the cycle it arrives, checks its heartbeat or
// XOR byte and stores a descriptor into a four-entry queue; the back end
// then emits one result per clock cycle, while the output register is free
// or being popped, from the head of that queue into a single output
// register. A frame has one to nine results, nine for the vehicle-state
// frame, and results appear back to back across frames as long as pop
// is held high. The earliest result of a frame passes through its queue
// entry and the output register before it is visible. The descriptor of the frame being
// emitted stays at the head of the queue until its last result has been
// registered, so up to three classified frames can wait behind it; the
// input side keeps accepting frames while the output side is stalled until
// that queue fills.
module can_status_frame_decoder_unit
  import cscd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [28:0]        frame_id_i,
  input  logic [7:0]         byte0_i,
  input  logic [7:0]         byte1_i,
  input  logic [7:0]         byte2_i,
  input  logic [7:0]         byte3_i,
  input  logic [7:0]         byte4_i,
  input  logic [7:0]         byte5_i,
  input  logic [7:0]         byte6_i,
  input  logic [7:0]         byte7_i,
  output logic               empty,
  input  logic               pop,
  output logic [4:0]         signal_code_o,
  output logic signed [16:0] signal_value_o,
  output logic               last_of_frame_o
);

  // Descriptor queue wiring between the two halves.
  logic      q_wr;
  logic      q_rd;
  desc_t     q_wr_desc;
  desc_t     q_head;
  q_status_t q_status;

  // The input side is full exactly when no descriptor slot is free.
  assign full = q_status.full;

  cscd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .q_status_i (q_status),
    .frame_id_i (frame_id_i),
    .byte0_i    (byte0_i),
    .byte1_i    (byte1_i),
    .byte2_i    (byte2_i),
    .byte3_i    (byte3_i),
    .byte4_i    (byte4_i),
    .byte5_i    (byte5_i),
    .byte6_i    (byte6_i),
    .byte7_i    (byte7_i),
    .wr_o       (q_wr),
    .desc_o     (q_wr_desc)
  );

  cscd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_desc_i (q_wr_desc),
    .rd_i      (q_rd),
    .rd_desc_o (q_head),
    .status_o  (q_status)
  );

  // The back end releases a descriptor once its last result is registered.
  cscd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .q_status_i      (q_status),
    .rd_o            (q_rd),
    .pop_i           (pop),
    .empty_o         (empty),
    .signal_code_o   (signal_code_o),
    .signal_value_o  (signal_value_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

### hw/rtl/cscd_front.sv
// Front end of the CAN status frame decoder: identifier classification,
// liveness checks, heartbeat state and the divide-by-five multiply.
// Depends on cscd_pkg.
`timescale 1ns / 1ps

module cscd_front
  import cscd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  q_status_t   q_status_i,
  input  logic [28:0] frame_id_i,
  input  logic [7:0]  byte0_i,
  input  logic [7:0]  byte1_i,
  input  logic [7:0]  byte2_i,
  input  logic [7:0]  byte3_i,
  input  logic [7:0]  byte4_i,
  input  logic [7:0]  byte5_i,
  input  logic [7:0]  byte6_i,
  input  logic [7:0]  byte7_i,
  output logic        wr_o,
  output desc_t       desc_o
);

  logic        accept;
  logic        known;
  logic        is_eps;
  logic        is_veh;
  logic [7:0]  xor7;
  logic [7:0]  eps_hb_q, eps_hb_d;
  logic [7:0]  veh_hb_q, veh_hb_d;
  logic [31:0] prod;

  assign accept = push_i & ~q_status_i.full;
  assign is_eps = (frame_id_i == ID_EPS);
  assign is_veh = (frame_id_i == ID_VEHICLE);
  assign xor7   = byte0_i ^ byte1_i ^ byte2_i ^ byte3_i ^ byte4_i ^ byte5_i ^ byte6_i;
  assign prod   = {byte3_i, byte2_i} * RECIP5;

  always_comb begin
    known             = 1'b1;
    desc_o.first_code = SC_EPS_RUN_MODE;
    desc_o.last_code  = SC_EPS_LINK;
    desc_o.link_ok    = 1'b0;
    desc_o.data       = {byte6_i, byte5_i, byte4_i, byte3_i, byte2_i, byte1_i, byte0_i};
    desc_o.quot       = prod[RECIP5_SHIFT +: QUOT_W];
    case (frame_id_i)
      ID_EPS: begin
        desc_o.link_ok = (8'(eps_hb_q + 8'd1) == byte7_i);
      end
      ID_DRIVE: begin
        desc_o.first_code = SC_DRV_EPB;
        desc_o.last_code  = SC_DRV_LINK;
        desc_o.link_ok    = (xor7 == byte7_i);
      end
      ID_VEHICLE: begin
        desc_o.first_code = SC_VEH_DRV_MODE;
        desc_o.last_code  = SC_VEH_LINK;
        desc_o.link_ok    = (8'(veh_hb_q + 8'd1) == byte7_i);
      end
      ID_BATTERY: begin
        desc_o.first_code = SC_BAT_VOLTAGE;
        desc_o.last_code  = SC_BAT_CURRENT;
      end
      ID_POWER: begin
        desc_o.first_code = SC_PWR_STATE;
        desc_o.last_code  = SC_PWR_STATE;
      end
      ID_FAULT: begin
        desc_o.first_code = SC_FLT_ISOLATION;
        desc_o.last_code  = SC_FLT_MCU;
      end
      ID_BRAKE: begin
        desc_o.first_code = SC_BRK_MODE;
        desc_o.last_code  = SC_BRK_LINK;
        desc_o.link_ok    = (xor7 == byte7_i);
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Frames without results are accepted and simply dropped here.
  assign wr_o = accept & known;

  always_comb begin
    eps_hb_d = eps_hb_q;
    veh_hb_d = veh_hb_q;
    if (accept && is_eps) begin
      eps_hb_d = byte7_i;
    end
    if (accept && is_veh) begin
      veh_hb_d = byte7_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_hb_q <= HB_RESET;
      veh_hb_q <= HB_RESET;
    end else begin
      eps_hb_q <= eps_hb_d;
      veh_hb_q <= veh_hb_d;
    end
  end

  a_eps_hb_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_eps) |=> (eps_hb_q == $past(byte7_i)))
    else $error("EPS heartbeat not updated from accepted frame");

  a_veh_hb_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && is_veh) |=> $stable(veh_hb_q))
    else $error("vehicle heartbeat changed without a vehicle-state frame");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o |-> (desc_o.first_code <= desc_o.last_code) && !q_status_i.full)
    else $error("bad descriptor written");

endmodule

### hw/rtl/cscd_queue.sv
// Descriptor queue between the front and back end of the frame decoder.
// Depends on cscd_pkg.
`timescale 1ns / 1ps

module cscd_queue
  import cscd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  desc_t     wr_desc_i,
  input  logic      rd_i,
  output desc_t     rd_desc_o,
  output q_status_t status_o
);

  desc_t           mem_q [Q_DEPTH];
  logic [Q_AW:0]   wptr_q, wptr_d;
  logic [Q_AW:0]   rptr_q, rptr_d;

  assign status_o.empty = (wptr_q == rptr_q);
  assign status_o.full  = (wptr_q[Q_AW] != rptr_q[Q_AW]) &&
                          (wptr_q[Q_AW-1:0] == rptr_q[Q_AW-1:0]);
  assign rd_desc_o      = mem_q[rptr_q[Q_AW-1:0]];

  assign wptr_d = wr_i ? wptr_q + 1'b1 : wptr_q;
  assign rptr_d = rd_i ? rptr_q + 1'b1 : rptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q[Q_AW-1:0]] <= wr_desc_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && status_o.full))
    else $error("write into full descriptor queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_i && status_o.empty))
    else $error("read from empty descriptor queue");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((Q_AW+1)'(wptr_q - rptr_q) <= (Q_AW+1)'(Q_DEPTH)))
    else $error("descriptor queue fill level out of range");

endmodule

### hw/rtl/cscd_back.sv
// Back end of the frame decoder: walks the code range of the head descriptor,
// computes one decoded value per cycle while the output register is free or
// being popped, and holds it in that register. Depends on cscd_pkg.
`timescale 1ns / 1ps

module cscd_back
  import cscd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  desc_t              head_i,
  input  q_status_t          q_status_i,
  output logic               rd_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [4:0]         signal_code_o,
  output logic signed [16:0] signal_value_o,
  output logic               last_of_frame_o
);

  logic               busy_q, busy_d;
  logic [4:0]         code_q, code_d;
  logic [4:0]         code;
  logic               slot_free;
  logic               emit;
  logic               last;
  logic               out_valid_q, out_valid_d;
  logic [4:0]         out_code_q;
  logic signed [16:0] out_value_q;
  logic               out_last_q;
  logic signed [16:0] value;
  logic [7:0]         b0, b1, b2, b3, b4, b5, b6;
  logic [15:0]        raw21, raw43;

  assign b0 = head_i.data[0];
  assign b1 = head_i.data[1];
  assign b2 = head_i.data[2];
  assign b3 = head_i.data[3];
  assign b4 = head_i.data[4];
  assign b5 = head_i.data[5];
  assign b6 = head_i.data[6];
  assign raw21 = {b2, b1};
  assign raw43 = {b4, b3};

  assign code      = busy_q ? code_q : head_i.first_code;
  assign slot_free = ~out_valid_q | pop_i;
  assign emit      = ~q_status_i.empty & slot_free;
  assign last      = (code == head_i.last_code);
  assign rd_o      = emit & last;

  always_comb begin
    value = '0;
    case (code)
      SC_EPS_RUN_MODE:   value = $signed({9'd0, b0});
      SC_EPS_DRV_TORQUE: value = (b1 == 8'd0) ? '0 : $signed({9'd0, b1}) - 17'sd128;
      SC_EPS_TORQUE:     value = (b2 == 8'd0) ? '0 :
                                 $signed({7'd0, b2, 1'b0} + {9'd0, b2}) - 17'sd384;
      SC_EPS_ANGLE:      value = (raw43 == 16'd0) ? '0 :
                                 $signed({1'b0, raw43}) - 17'sd10800;
      SC_EPS_TEMP:       value = $signed({10'd0, b5[5:0], 1'b0});
      SC_EPS_ERR_LEVEL:  value = $signed({15'd0, b6[1:0]});
      SC_EPS_LINK:       value = $signed({16'd0, head_i.link_ok});
      SC_DRV_EPB:        value = $signed({15'd0, b0[1:0]});
      SC_DRV_GEAR:       value = $signed({15'd0, b0[3:2]});
      SC_DRV_MOT_SPEED:  value = (raw21 == 16'd0 || raw21 >= 16'd30000) ? '0 :
                                 $signed({1'b0, raw21}) - 17'sd15000;
      SC_DRV_MOT_TORQUE: value = (raw43 > 16'd10000) ? '0 :
                                 $signed({1'b0, raw43}) - 17'sd5000;
      SC_DRV_ACCEL:      value = $signed({9'd0, b6}) - 17'sd128;
      SC_DRV_LINK:       value = $signed({16'd0, head_i.link_ok});
      SC_VEH_DRV_MODE:   value = $signed({15'd0, b0[1:0]});
      SC_VEH_DOOR:       value = $signed({16'd0, b0[2]});
      SC_VEH_SPEED:      value = (b2 == 8'd0) ? '0 : $signed({9'd0, b2}) - 17'sd50;
      SC_VEH_SOC:        value = $signed({9'd0, b3});
      SC_VEH_SMART_PWR:  value = $signed({15'd0, b4[1:0]});
      SC_VEH_CHG_STATE:  value = $signed({15'd0, b4[3:2]});
      SC_VEH_CHG_CONN:   value = $signed({15'd0, b4[5:4]});
      SC_VEH_FAULT_LVL:  value = $signed({15'd0, b4[7:6]});
      SC_VEH_LINK:       value = $signed({16'd0, head_i.link_ok});
      // Doubling drops the top bit of the raw voltage.
      SC_BAT_VOLTAGE:    value = $signed({1'b0, b1[6:0], b0, 1'b0});
      SC_BAT_CURRENT:    value = (head_i.quot == '0 ||
                                  head_i.quot >= QUOT_W'(13100)) ? '0 :
                                 $signed({3'd0, head_i.quot}) - 17'sd5000;
      SC_PWR_STATE:      value = $signed({15'd0, b2[5:4]});
      SC_FLT_ISOLATION:  value = $signed({15'd0, b0[1:0]});
      SC_FLT_BMS:        value = $signed({15'd0, b3[1:0]});
      SC_FLT_MCU:        value = $signed({15'd0, b3[3:2]});
      SC_BRK_MODE:       value = $signed({9'd0, b0});
      SC_BRK_FORCE:      value = $signed({9'd0, b1});
      SC_BRK_LINK:       value = $signed({16'd0, head_i.link_ok});
      default:           value = '0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    code_d      = code_q;
    out_valid_d = out_valid_q & ~pop_i;
    if (emit) begin
      out_valid_d = 1'b1;
      busy_d      = ~last;
      code_d      = code + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      code_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_code_q  <= code;
      out_value_q <= value;
      out_last_q  <= last;
    end
  end

  assign empty_o         = ~out_valid_q;
  assign signal_code_o   = out_code_q;
  assign signal_value_o  = out_value_q;
  assign last_of_frame_o = out_last_q;

  a_busy_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !q_status_i.empty)
    else $error("sequencer busy with no descriptor at the queue head");

  a_code_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (code >= head_i.first_code) && (code <= head_i.last_code))
    else $error("emitted code outside the frame's code range");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(out_code_q)))
    else $error("waiting result lost or overwritten");

endmodule

### bench/can_status_frame_decoder_unit_tb.sv
// Self-checking bench for can_status_frame_decoder_unit: a table of directed frames,
// then random frames with idle and stall patterns on both queue sides.
// Depends on cscd_pkg and the decoder RTL; needs no files or arguments.
`timescale 1ns / 1ps

module can_status_frame_decoder_unit_tb
  import cscd_pkg::*;
();

  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned RANDOM_FRAMES = 195;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_AFTER    = 40;
  localparam int unsigned PAUSE_AT      = 150;
  localparam int unsigned CALM_FIRST    = 90;
  localparam int unsigned CALM_LAST     = 130;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 30;
  localparam int unsigned IDLE_PERCENT  = 24;

  // This identifier is listed by the bus but must be swallowed without a result.
  localparam logic [28:0] ID_SILENT = 29'h1811A0B0;

  // Data bytes are packed so that a hex literal reads b0 first, b7 last.
  typedef struct packed {
    logic [28:0]     id;
    logic [0:7][7:0] data;
  } frame_t;

  // A directed row may pin the value of one of its signals to a hand-read figure.
  typedef struct packed {
    frame_t             frame;
    logic               pinned;
    logic [4:0]         pin_code;
    logic signed [16:0] pin_value;
  } row_t;

  typedef struct packed {
    logic [4:0]         code;
    logic signed [16:0] value;
    logic               last;
  } signal_t;

  localparam logic [28:0] KNOWN_IDS [7] = '{ID_EPS, ID_DRIVE, ID_VEHICLE, ID_BATTERY,
                                            ID_POWER, ID_FAULT, ID_BRAKE};

  // Raw 16-bit values on either side of the zeroing thresholds.
  localparam logic [15:0] SPEED_EDGES   [5] = '{16'd0, 16'd1, 16'd29999, 16'd30000, 16'd65535};
  localparam logic [15:0] TORQUE_EDGES  [5] = '{16'd0, 16'd1, 16'd10000, 16'd10001, 16'd65535};
  localparam logic [15:0] CURRENT_EDGES [6] = '{16'd0, 16'd4, 16'd5, 16'd65499, 16'd65500,
                                               16'd65535};

  localparam int unsigned DIR_ROWS = 25;

  // Directed frames. Pinned values are read straight off the decoding rules; every
  // other signal of these frames is checked against the decoder model below.
  localparam row_t DIRECTED [DIR_ROWS] = '{
    // Heartbeat wrap: the reset value of 255 accepts 0 as its successor.
    '{'{ID_EPS,     64'h00_00_00_00_00_00_00_00}, 1'b1, SC_EPS_LINK,        17'sd1},
    '{'{ID_EPS,     64'h00_FF_FF_FF_FF_FF_FF_00}, 1'b1, SC_EPS_ANGLE,       17'sd54735},
    '{'{ID_EPS,     64'h3F_01_01_01_00_C0_FC_01}, 1'b1, SC_EPS_TORQUE,     -17'sd381},
    '{'{ID_EPS,     64'h80_80_80_00_01_3F_03_55}, 1'b1, SC_EPS_TEMP,        17'sd126},
    '{'{ID_DRIVE,   64'h00_00_00_00_00_00_00_00}, 1'b1, SC_DRV_MOT_TORQUE, -17'sd5000},
    '{'{ID_DRIVE,   64'h00_01_00_10_27_00_00_36}, 1'b1, SC_DRV_MOT_SPEED,  -17'sd14999},
    '{'{ID_DRIVE,   64'h00_2F_75_11_27_00_00_6C}, 1'b1, SC_DRV_MOT_SPEED,   17'sd14999},
    '{'{ID_DRIVE,   64'hFF_30_75_FF_FF_00_FF_00}, 1'b1, SC_DRV_MOT_SPEED,   17'sd0},
    '{'{ID_VEHICLE, 64'h00_00_00_00_00_00_00_00}, 1'b1, SC_VEH_LINK,        17'sd1},
    '{'{ID_VEHICLE, 64'hFF_FF_FF_FF_FF_FF_FF_5A}, 1'b1, SC_VEH_SPEED,       17'sd205},
    '{'{ID_VEHICLE, 64'h04_00_01_00_E4_00_00_5B}, 1'b1, SC_VEH_LINK,        17'sd1},
    '{'{ID_VEHICLE, 64'h03_00_32_64_1B_00_00_5D}, 1'b0, SC_VEH_LINK,        17'sd0},
    // Battery voltage overflow: doubling the full raw value keeps the low 16 bits.
    '{'{ID_BATTERY, 64'hFF_FF_00_00_00_00_00_00}, 1'b1, SC_BAT_VOLTAGE,     17'sd65534},
    '{'{ID_BATTERY, 64'h34_12_DB_FF_00_00_00_00}, 1'b1, SC_BAT_CURRENT,     17'sd8099},
    '{'{ID_BATTERY, 64'h00_80_DC_FF_00_00_00_00}, 1'b1, SC_BAT_CURRENT,     17'sd0},
    '{'{ID_BATTERY, 64'h01_00_05_00_00_00_00_00}, 1'b1, SC_BAT_CURRENT,    -17'sd4999},
    '{'{ID_POWER,   64'h00_00_FF_00_00_00_00_00}, 1'b1, SC_PWR_STATE,       17'sd3},
    '{'{ID_POWER,   64'hFF_FF_CF_FF_FF_FF_FF_FF}, 1'b1, SC_PWR_STATE,       17'sd0},
    '{'{ID_FAULT,   64'hFF_00_00_FF_00_00_00_00}, 1'b1, SC_FLT_MCU,         17'sd3},
    '{'{ID_FAULT,   64'h02_FF_FF_06_FF_FF_FF_FF}, 1'b0, SC_FLT_MCU,         17'sd0},
    '{'{ID_BRAKE,   64'hFF_FF_FF_FF_FF_FF_FF_FF}, 1'b1, SC_BRK_LINK,        17'sd1},
    '{'{ID_BRAKE,   64'hFF_FF_FF_FF_FF_FF_FF_00}, 1'b1, SC_BRK_LINK,        17'sd0},
    // Identifiers that must produce nothing and leave the heartbeats alone.
    '{'{ID_SILENT,  64'hFF_FF_FF_FF_FF_FF_FF_FF}, 1'b0, SC_EPS_RUN_MODE,    17'sd0},
    '{'{29'h1FFFFFFF, 64'h00_00_00_00_00_00_00_00}, 1'b0, SC_EPS_RUN_MODE,  17'sd0},
    '{'{29'h0000000, 64'hFF_FF_FF_FF_FF_FF_FF_FF}, 1'b0, SC_EPS_RUN_MODE,   17'sd0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [28:0]        frame_id_i;
  logic [7:0]         byte0_i, byte1_i, byte2_i, byte3_i;
  logic [7:0]         byte4_i, byte5_i, byte6_i, byte7_i;
  logic               empty;
  logic               pop;
  logic [4:0]         signal_code_o;
  logic signed [16:0] signal_value_o;
  logic               last_of_frame_o;

  // Model state: the two stored heartbeat bytes and the signals still owed.
  logic [7:0] eps_beat;
  logic [7:0] veh_beat;
  signal_t    expected_signals [$];

  int unsigned frames_accepted = 0;
  int unsigned silent_frames   = 0;
  int unsigned signals_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned stall_cycles    = 0;
  bit          calm_phase      = 1'b0;
  bit          held_off        = 1'b0;

  can_status_frame_decoder_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .frame_id_i      (frame_id_i),
    .byte0_i         (byte0_i),
    .byte1_i         (byte1_i),
    .byte2_i         (byte2_i),
    .byte3_i         (byte3_i),
    .byte4_i         (byte4_i),
    .byte5_i         (byte5_i),
    .byte6_i         (byte6_i),
    .byte7_i         (byte7_i),
    .empty           (empty),
    .pop             (pop),
    .signal_code_o   (signal_code_o),
    .signal_value_o  (signal_value_o),
    .last_of_frame_o (last_of_frame_o)
  );

  // 8 ns clock period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void owe_signal(input logic [4:0] code, input int value);
    signal_t s;
    s.code  = code;
    s.value = value[16:0];
    s.last  = 1'b0;
    expected_signals.push_back(s);
  endfunction

  // Decodes one accepted frame into the signals it owes and updates the heartbeats.
  // Returns how many signals the frame produces.
  function automatic int decode_frame(input frame_t f);
    int b [8];
    int v;
    int base;
    int parity;
    base = expected_signals.size();
    for (int i = 0; i < 8; i++) b[i] = f.data[i];
    parity = b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4] ^ b[5] ^ b[6];
    case (f.id)
      ID_EPS: begin
        owe_signal(SC_EPS_RUN_MODE, b[0]);
        owe_signal(SC_EPS_DRV_TORQUE, b[1] != 0 ? b[1] - 128 : 0);
        owe_signal(SC_EPS_TORQUE, b[2] != 0 ? 3 * b[2] - 384 : 0);
        owe_signal(SC_EPS_ANGLE, (b[3] | b[4]) != 0 ? b[3] + 256 * b[4] - 10800 : 0);
        owe_signal(SC_EPS_TEMP, 2 * (b[5] & 'h3F));
        owe_signal(SC_EPS_ERR_LEVEL, b[6] & 3);
        owe_signal(SC_EPS_LINK, int'(8'(eps_beat + 8'd1) == f.data[7]));
        eps_beat = f.data[7];
      end
      ID_DRIVE: begin
        owe_signal(SC_DRV_EPB, b[0] & 3);
        owe_signal(SC_DRV_GEAR, (b[0] >> 2) & 3);
        v = 256 * b[2] + b[1] - 15000;
        owe_signal(SC_DRV_MOT_SPEED, (v >= 15000 || v <= -15000) ? 0 : v);
        v = 256 * b[4] + b[3] - 5000;
        owe_signal(SC_DRV_MOT_TORQUE, (v > 5000 || v < -5000) ? 0 : v);
        owe_signal(SC_DRV_ACCEL, b[6] - 128);
        owe_signal(SC_DRV_LINK, int'(parity == b[7]));
      end
      ID_VEHICLE: begin
        owe_signal(SC_VEH_DRV_MODE, b[0] & 3);
        owe_signal(SC_VEH_DOOR, (b[0] >> 2) & 1);
        owe_signal(SC_VEH_SPEED, b[2] != 0 ? b[2] - 50 : 0);
        owe_signal(SC_VEH_SOC, b[3]);
        owe_signal(SC_VEH_SMART_PWR, b[4] & 3);
        owe_signal(SC_VEH_CHG_STATE, (b[4] >> 2) & 3);
        owe_signal(SC_VEH_CHG_CONN, (b[4] >> 4) & 3);
        owe_signal(SC_VEH_FAULT_LVL, (b[4] >> 6) & 3);
        owe_signal(SC_VEH_LINK, int'(8'(veh_beat + 8'd1) == f.data[7]));
        veh_beat = f.data[7];
      end
      ID_BATTERY: begin
        owe_signal(SC_BAT_VOLTAGE, (2 * (b[0] + 256 * b[1])) & 'hFFFF);
        v = (b[2] + 256 * b[3]) / 5 - 5000;
        owe_signal(SC_BAT_CURRENT, (v <= -5000 || v >= 8100) ? 0 : v);
      end
      ID_POWER: owe_signal(SC_PWR_STATE, (b[2] >> 4) & 3);
      ID_FAULT: begin
        owe_signal(SC_FLT_ISOLATION, b[0] & 3);
        owe_signal(SC_FLT_BMS, b[3] & 3);
        owe_signal(SC_FLT_MCU, (b[3] >> 2) & 3);
      end
      ID_BRAKE: begin
        owe_signal(SC_BRK_MODE, b[0]);
        owe_signal(SC_BRK_FORCE, b[1]);
        owe_signal(SC_BRK_LINK, int'(parity == b[7]));
      end
      default: ;
    endcase
    if (expected_signals.size() > base)
      expected_signals[expected_signals.size() - 1].last = 1'b1;
    return expected_signals.size() - base;
  endfunction

  // Random frame: mostly known identifiers with well-formed heartbeat or XOR bytes,
  // with some unknown identifiers, broken liveness bytes and threshold raw values.
  function automatic frame_t random_frame();
    frame_t     f;
    int unsigned pick;
    logic [7:0] parity;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(15))
        0:       f.data[i] = 8'h00;
        1:       f.data[i] = 8'hFF;
        default: f.data[i] = 8'($urandom);
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 10)      f.id = 29'($urandom);
    else if (pick < 14) f.id = ID_SILENT;
    else                f.id = KNOWN_IDS[$urandom_range(6)];
    if (f.id == ID_DRIVE && $urandom_range(3) == 0)
      {f.data[2], f.data[1]} = SPEED_EDGES[$urandom_range(4)];
    if (f.id == ID_DRIVE && $urandom_range(3) == 0)
      {f.data[4], f.data[3]} = TORQUE_EDGES[$urandom_range(4)];
    if (f.id == ID_BATTERY && $urandom_range(3) == 0)
      {f.data[3], f.data[2]} = CURRENT_EDGES[$urandom_range(5)];
    parity = f.data[0] ^ f.data[1] ^ f.data[2] ^ f.data[3] ^ f.data[4] ^ f.data[5] ^ f.data[6];
    if ($urandom_range(3) != 0) begin
      case (f.id)
        ID_EPS:             f.data[7] = eps_beat + 8'd1;
        ID_VEHICLE:         f.data[7] = veh_beat + 8'd1;
        ID_DRIVE, ID_BRAKE: f.data[7] = parity;
        default: ;
      endcase
    end
    return f;
  endfunction

  // Offers one frame from the next falling edge, with random idle cycles first, and
  // returns at the rising edge of its transfer with the owed signals queued.
  task automatic send_frame(input frame_t f, input logic pinned, input logic [4:0] pin_code,
                            input logic signed [16:0] pin_value, output int produced);
    int base;
    @(negedge clk_i);
    while (!calm_phase && $urandom_range(99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push       <= 1'b1;
    frame_id_i <= f.id;
    byte0_i    <= f.data[0];
    byte1_i    <= f.data[1];
    byte2_i    <= f.data[2];
    byte3_i    <= f.data[3];
    byte4_i    <= f.data[4];
    byte5_i    <= f.data[5];
    byte6_i    <= f.data[6];
    byte7_i    <= f.data[7];
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    frames_accepted++;
    // No time passes from here on, so the result checker cannot shift the queue.
    base     = expected_signals.size();
    produced = decode_frame(f);
    if (produced == 0) silent_frames++;
    if (pinned) begin
      for (int j = base; j < expected_signals.size(); j++)
        if (expected_signals[j].code == pin_code) expected_signals[j].value = pin_value;
    end
  endtask

  // Sender: reset, the directed table, then random frames with one full drain pause.
  initial begin
    frame_t      f;
    int          produced;
    int unsigned known_sent;
    bit          paused;
    known_sent = 0;
    paused     = 1'b0;
    eps_beat   = HB_RESET;
    veh_beat   = HB_RESET;
    rst_ni     = 1'b0;
    push       = 1'b0;
    frame_id_i = '0;
    {byte0_i, byte1_i, byte2_i, byte3_i} = '0;
    {byte4_i, byte5_i, byte6_i, byte7_i} = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < DIR_ROWS; r++)
      send_frame(DIRECTED[r].frame, DIRECTED[r].pinned, DIRECTED[r].pin_code,
                 DIRECTED[r].pin_value, produced);

    // Frames that produce nothing do not count towards the random total.
    while (known_sent < RANDOM_FRAMES) begin
      if (known_sent == PAUSE_AT && !paused) begin
        paused = 1'b1;
        @(negedge clk_i);
        push <= 1'b0;
        while (expected_signals.size() != 0) @(posedge clk_i);
      end
      calm_phase = (known_sent >= CALM_FIRST && known_sent < CALM_LAST);
      f = random_frame();
      send_frame(f, 1'b0, SC_EPS_RUN_MODE, '0, produced);
      if (produced != 0) known_sent++;
    end
    calm_phase = 1'b0;

    @(negedge clk_i);
    push <= 1'b0;
    while (expected_signals.size() != 0) @(posedge clk_i);
    // Keep sampling for DRAIN_CYCLES so that any stray result is caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d frames (%0d with no result) and %0d decoded signals,",
             frames_accepted, silent_frames, signals_checked);
    $display("with a %0d-cycle output hold-off and a full drain pause mid-run.", HOLD_CYCLES);
    if (mismatches == 0 && expected_signals.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: pops at random, holds off once for a long stretch so that the internal
  // queue fills and full rises, and pops on every cycle during the calm phase.
  initial begin
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held_off && frames_accepted >= HOLD_AFTER) begin
        held_off = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (calm_phase) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Every transfer out of the decoder is compared with the oldest owed signal.
  always @(posedge clk_i) begin : result_check
    signal_t want;
    if (rst_ni && pop && !empty) begin
      signals_checked++;
      if (expected_signals.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got code %0d value %0d last %0d",
                 $time, signal_code_o, signal_value_o, last_of_frame_o);
      end else begin
        want = expected_signals.pop_front();
        if (signal_code_o !== want.code) begin
          mismatches++;
          $display("%0t: signal_code expected %0d, got %0d", $time, want.code, signal_code_o);
        end
        if (signal_value_o !== want.value) begin
          mismatches++;
          $display("%0t: signal_value (code %0d) expected %0d, got %0d",
                   $time, want.code, want.value, signal_value_o);
        end
        if (last_of_frame_o !== want.last) begin
          mismatches++;
          $display("%0t: last_of_frame (code %0d) expected %0d, got %0d",
                   $time, want.code, want.last, last_of_frame_o);
        end
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on either side for too long.
  initial begin
    wait (rst_ni === 1'b1);
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
